[rtl/bmalloc_pkg.sv]
// bitmap allocator package: widths, request codes and register map
package bmalloc_pkg;

  localparam int unsigned MAX_BITS_DEF = 1024;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned OFF_W = 6;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [ACT_W-1:0] ACT_SET = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FIND = 2'd2;

  localparam logic REG_BITMAP_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

endpackage

[rtl/bitmap_allocator.sv]
// bitmap allocator top level: sequencer, size register and apb port
// A request is taken when start is high and busy is low; its result appears as a
// registered single-cycle done_o beat that cannot be held off. A set or clear in
// range reads the 64-bit word, then modifies and writes it back; a find scans the
// 64-bit words in turn through the single word port of the bitmap store, at most
// ceil(min(bitmap_size, MAX_BITS) / 64) of them; a request that fails at once does
// not touch the store. After reset the store is cleared one word a cycle, all
// ceil(MAX_BITS / 64) words, with busy high.
module bitmap_allocator #(
  parameter int unsigned MAX_BITS = bmalloc_pkg::MAX_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [bmalloc_pkg::ACT_W-1:0]     action_i,
  input  logic [bmalloc_pkg::IDX_W-1:0]     bit_index_i,
  output logic                              done_o,
  output logic                              ok_o,
  output logic [bmalloc_pkg::IDX_W-1:0]     found_index_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmalloc_pkg::PADDR_W-1:0]   paddr,
  input  logic [bmalloc_pkg::APB_DW-1:0]    pwdata,
  output logic [bmalloc_pkg::APB_DW-1:0]    prdata,
  output logic                              pready
);
  import bmalloc_pkg::*;

  localparam int unsigned NWORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned MB_W = $clog2(MAX_BITS + 1);
  localparam int unsigned CW = (MB_W > SIZE_W) ? MB_W : SIZE_W;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RMW  = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     w_q, w_d;
  logic [ACT_W-1:0]  act_q;
  logic [OFF_W-1:0]  bitsel_q;
  logic [SIZE_W-1:0] size_q;
  logic              done_q;
  logic              ok_q;
  logic [IDX_W-1:0]  fidx_q;

  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic [CW-1:0]     size_ext, eff, idx_ext, base, found;
  logic [CW:0]       next_base;
  logic              hit;
  logic [OFF_W-1:0]  off;
  logic              res_v, res_ok;
  logic [IDX_W-1:0]  res_idx;
  logic              cfg_we;

  bmalloc_mem #(
    .DEPTH(NWORDS),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  bmalloc_ffz #(
    .CW(CW)
  ) u_ffz (
    .word_i (mem_rdata),
    .base_i (base),
    .limit_i(eff),
    .hit_o  (hit),
    .off_o  (off)
  );

  always_comb begin
    size_ext  = CW'(size_q);
    eff       = (size_ext > CW'(MAX_BITS)) ? CW'(MAX_BITS) : size_ext;
    idx_ext   = CW'(bit_index_i);
    base      = CW'({w_q, {OFF_W{1'b0}}});
    next_base = {1'b0, base} + (CW + 1)'(WORD_W);
    found     = base + CW'(off);
  end

  always_comb begin
    state_d   = state_q;
    w_d       = w_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = w_q;
    mem_wdata = '0;
    res_v     = 1'b0;
    res_ok    = 1'b0;
    res_idx   = '0;
    case (state_q)
      ST_CLR: begin
        mem_we = 1'b1;
        if (w_q == AW'(NWORDS - 1)) begin
          w_d     = '0;
          state_d = ST_IDLE;
        end else begin
          w_d = w_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (action_i)
            ACT_SET, ACT_CLEAR: begin
              if (idx_ext < eff) begin
                mem_re   = 1'b1;
                mem_addr = idx_ext[AW+OFF_W-1:OFF_W];
                w_d      = idx_ext[AW+OFF_W-1:OFF_W];
                state_d  = ST_RMW;
              end else begin
                res_v = 1'b1;
              end
            end
            ACT_FIND: begin
              if (eff != '0) begin
                mem_re   = 1'b1;
                mem_addr = '0;
                w_d      = '0;
                state_d  = ST_SCAN;
              end else begin
                res_v = 1'b1;
              end
            end
            default: begin
              res_v = 1'b1;
            end
          endcase
        end
      end
      ST_RMW: begin
        mem_we              = 1'b1;
        mem_wdata           = mem_rdata;
        mem_wdata[bitsel_q] = (act_q == ACT_SET);
        res_v               = 1'b1;
        res_ok              = 1'b1;
        state_d             = ST_IDLE;
      end
      ST_SCAN: begin
        if (hit) begin
          res_v   = 1'b1;
          res_ok  = 1'b1;
          res_idx = found[IDX_W-1:0];
          state_d = ST_IDLE;
        end else if (next_base >= {1'b0, eff}) begin
          res_v   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mem_re   = 1'b1;
          mem_addr = w_q + 1'b1;
          w_d      = w_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      w_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      done_q  <= res_v;
    end
  end

  // request payload held for the read-modify-write, and the result registers
  always_ff @(posedge clk_i) begin
    if (start && state_q == ST_IDLE) begin
      act_q    <= action_i;
      bitsel_q <= idx_ext[OFF_W-1:0];
    end
    if (res_v) begin
      ok_q   <= res_ok;
      fidx_q <= res_idx;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign found_index_o = fidx_q;

  // apb register port
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BITMAP_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BITMAP_SIZE) ? APB_DW'(size_q) : '0;
  assign pready = 1'b1;

endmodule

[rtl/bmalloc_mem.sv]
// bitmap word store: one port, registered read
module bmalloc_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  logic                              clk_i,
  input  logic                              re_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     addr_i,
  input  logic [bmalloc_pkg::WORD_W-1:0]    wdata_i,
  output logic [bmalloc_pkg::WORD_W-1:0]    rdata_o
);
  import bmalloc_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bmalloc_ffz.sv]
// find-first-zero over one bitmap word, limited to entries below the size in use
module bmalloc_ffz #(
  parameter int unsigned CW = 11
) (
  input  logic [bmalloc_pkg::WORD_W-1:0] word_i,
  input  logic [CW-1:0]                  base_i,
  input  logic [CW-1:0]                  limit_i,
  output logic                           hit_o,
  output logic [bmalloc_pkg::OFF_W-1:0]  off_o
);
  import bmalloc_pkg::*;

  logic [CW-1:0]     rem;
  logic [WORD_W-1:0] valid;
  logic [WORD_W-1:0] free;

  always_comb begin
    rem = limit_i - base_i;
    if (rem >= CW'(WORD_W)) begin
      valid = '1;
    end else begin
      valid = ~({WORD_W{1'b1}} << rem[OFF_W-1:0]);
    end
    free = ~word_i & valid;
  end

  always_comb begin
    hit_o = |free;
    off_o = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free[j]) begin
        off_o = OFF_W'(j);
      end
    end
  end

endmodule
